### hdl/dmskt_pkg.sv
// ----------------------------------------------------------------------------
// dmskt_pkg
// Types and constants shared by the direct-mapped string key table.
// ----------------------------------------------------------------------------
package dmskt_pkg;

  localparam int KEY_BYTES   = 8;
  localparam int KEY_W       = 8 * KEY_BYTES;
  localparam int IDX_W       = $clog2(KEY_BYTES);
  localparam int QUEUE_DEPTH = 2;
  localparam int HASH_MUL    = 37;

  typedef enum logic [1:0] {
    OP_LOOKUP  = 2'd0,
    OP_INSERT  = 2'd1,
    OP_INIT    = 2'd2,
    OP_CLEANUP = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_READY = 2'd1,
    ST_COLLISION = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_HASH,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_EVAL,
    B_CLEAR
  } back_state_e;

  typedef struct packed {
    logic [1:0]       operation;
    logic [KEY_W-1:0] key_bytes;
    logic [3:0]       key_length;
    logic [7:0]       new_value;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [7:0] found_value;
    logic [1:0] status;
    logic       ready_flag;
  } out_item_t;

  typedef struct packed {
    logic             occupied;
    logic [3:0]       key_length;
    logic [KEY_W-1:0] key_bytes;
    logic [7:0]       value;
  } slot_t;

endpackage

### hdl/direct_mapped_string_key_table.sv
// ----------------------------------------------------------------------------
// direct_mapped_string_key_table
// Direct-mapped key/value table with polynomial (x37) string hash.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_data carries one operation per
//   transaction (lookup, insert, init, cleanup). Output channel
//   out_valid/out_stall/out_data returns exactly one result per transaction,
//   in order. A transaction is taken when valid is high and stall is low.
//   The front hashes one key byte per cycle for a lookup or insert with a
//   nonzero clamped length; other transactions skip the hashing. The back
//   end answers a result that needs no table access straight from idle and
//   does a RAM read, then compare and write, for a lookup or insert. A
//   two-entry queue lets the front hash the next key while the back end
//   works. An init on a cleared flag sweeps the slot RAM, one slot per
//   cycle, over all SLOT_COUNT slots, before its result appears.
//   Reset clears the ready flag and the output valid flag; slot contents
//   are left as they are and are cleared by the first init. When out_stall
//   is held, the result register holds, the queue fills and in_stall rises.
// ----------------------------------------------------------------------------
module direct_mapped_string_key_table #(
  parameter int SLOT_COUNT    = 64,
  parameter int MAX_KEY_BYTES = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dmskt_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dmskt_pkg::out_item_t out_data
);

  import dmskt_pkg::*;

  localparam int SW = $clog2(SLOT_COUNT);
  localparam int QW = $bits(in_item_t) + SW;

  logic          push, full, pop, empty;
  in_item_t      push_item, head_item;
  logic [SW-1:0] push_slot, head_slot;
  logic [QW-1:0] head_data;

  dmskt_front #(
    .SLOT_COUNT    (SLOT_COUNT),
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_item (push_item),
    .push_slot (push_slot),
    .full      (full)
  );

  dmskt_queue #(
    .DATA_W (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_item, push_slot}),
    .full      (full),
    .pop       (pop),
    .pop_data  (head_data),
    .empty     (empty)
  );

  assign head_item = head_data[QW-1:SW];
  assign head_slot = head_data[SW-1:0];

  dmskt_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (!empty),
    .head_item  (head_item),
    .head_slot  (head_slot),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

### hdl/dmskt_ram.sv
// ----------------------------------------------------------------------------
// dmskt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dmskt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/dmskt_front.sv
// ----------------------------------------------------------------------------
// dmskt_front
// Accepts transactions, normalizes the key and hashes it one byte per cycle.
// ----------------------------------------------------------------------------
module dmskt_front #(
  parameter int SLOT_COUNT    = 64,
  parameter int MAX_KEY_BYTES = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  dmskt_pkg::in_item_t           in_data,
  output logic                          push,
  output dmskt_pkg::in_item_t           push_item,
  output logic [$clog2(SLOT_COUNT)-1:0] push_slot,
  input  logic                          full
);

  import dmskt_pkg::*;

  localparam int SW = $clog2(SLOT_COUNT);
  localparam int RW = SW + 9;

  front_state_e     state_r, state_nxt;
  in_item_t         item_r, item_nxt;
  logic [SW-1:0]    slot_r, slot_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  logic [3:0]       len_c;
  logic [KEY_W-1:0] key_m;
  logic [RW-1:0]    acc;
  logic             last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    slot_r <= slot_nxt;
    idx_r  <= idx_nxt;
  end

  always_comb begin
    len_c = (in_data.key_length > 4'(MAX_KEY_BYTES)) ? 4'(MAX_KEY_BYTES)
                                                      : in_data.key_length;
    key_m = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (4'(i) < len_c) begin
        key_m[8*i +: 8] = in_data.key_bytes[8*i +: 8];
      end
    end

    // residue step: (r*37 + byte) mod SLOT_COUNT, quotient below 256
    acc = (RW'(slot_r) << 5) + (RW'(slot_r) << 2) + RW'(slot_r)
        + RW'(item_r.key_bytes[8*idx_r +: 8]);
    for (int k = 7; k >= 0; k--) begin
      if (acc >= (RW'(SLOT_COUNT) << k)) begin
        acc = acc - (RW'(SLOT_COUNT) << k);
      end
    end

    last_byte = ({1'b0, idx_r} + 4'd1) == item_r.key_length;
  end

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    slot_nxt  = slot_r;
    idx_nxt   = idx_r;
    push      = 1'b0;
    in_stall  = (state_r != F_IDLE);

    unique case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          item_nxt.operation  = in_data.operation;
          item_nxt.key_bytes  = key_m;
          item_nxt.key_length = len_c;
          item_nxt.new_value  = in_data.new_value;
          slot_nxt = '0;
          idx_nxt  = '0;
          if ((in_data.operation == OP_LOOKUP || in_data.operation == OP_INSERT)
              && len_c != 4'd0) begin
            state_nxt = F_HASH;
          end else begin
            state_nxt = F_PUSH;
          end
        end
      end
      F_HASH: begin
        slot_nxt = acc[SW-1:0];
        idx_nxt  = idx_r + 1'b1;
        if (last_byte) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        push = 1'b1;
        if (!full) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  assign push_item = item_r;
  assign push_slot = slot_r;

endmodule

### hdl/dmskt_queue.sv
// ----------------------------------------------------------------------------
// dmskt_queue
// Short FIFO between the hashing front and the table back end.
// ----------------------------------------------------------------------------
module dmskt_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              empty
);

  import dmskt_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] mem_r [QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              do_push, do_pop;

  assign full     = (count_r == CW'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### hdl/dmskt_back.sv
// ----------------------------------------------------------------------------
// dmskt_back
// Executes queued operations against the slot RAM and drives the result.
// ----------------------------------------------------------------------------
module dmskt_back #(
  parameter int SLOT_COUNT = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          head_valid,
  input  dmskt_pkg::in_item_t           head_item,
  input  logic [$clog2(SLOT_COUNT)-1:0] head_slot,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output dmskt_pkg::out_item_t          out_data
);

  import dmskt_pkg::*;

  localparam int SW = $clog2(SLOT_COUNT);

  back_state_e   state_r, state_nxt;
  logic          ready_r, ready_nxt;
  logic [SW-1:0] clr_idx_r, clr_idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;

  logic          ram_we, ram_re;
  logic [SW-1:0] ram_waddr;
  slot_t         ram_wdata, ram_rdata;
  logic          out_free, match;

  dmskt_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (head_slot),
    .rd_data (ram_rdata)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign match    = ram_rdata.occupied
                 && ram_rdata.key_length == head_item.key_length
                 && ram_rdata.key_bytes == head_item.key_bytes;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ready_r     <= ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    clr_idx_r  <= clr_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    ready_nxt     = ready_r;
    clr_idx_nxt   = clr_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = head_slot;
    ram_wdata.occupied   = 1'b1;
    ram_wdata.key_length = head_item.key_length;
    ram_wdata.key_bytes  = head_item.key_bytes;
    ram_wdata.value      = head_item.new_value;

    unique case (state_r)
      B_IDLE: begin
        if (head_valid && out_free) begin
          out_data_nxt.found       = 1'b0;
          out_data_nxt.found_value = '0;
          out_data_nxt.status      = ST_OK;
          out_data_nxt.ready_flag  = ready_r;
          unique case (head_item.operation)
            OP_INIT: begin
              if (ready_r) begin
                out_valid_nxt = 1'b1;
                pop           = 1'b1;
              end else begin
                // sweep clears every occupied mark; the transaction then
                // completes from idle with the flag set
                clr_idx_nxt = '0;
                state_nxt   = B_CLEAR;
              end
            end
            OP_CLEANUP: begin
              ready_nxt               = 1'b0;
              out_data_nxt.ready_flag = 1'b0;
              out_valid_nxt           = 1'b1;
              pop                     = 1'b1;
            end
            default: begin
              if (!ready_r) begin
                out_data_nxt.status = ST_NOT_READY;
                out_valid_nxt       = 1'b1;
                pop                 = 1'b1;
              end else begin
                ram_re    = 1'b1;
                state_nxt = B_EVAL;
              end
            end
          endcase
        end
      end
      B_EVAL: begin
        if (out_free) begin
          out_data_nxt.found       = 1'b0;
          out_data_nxt.found_value = '0;
          out_data_nxt.status      = ST_OK;
          out_data_nxt.ready_flag  = ready_r;
          if (head_item.operation == OP_LOOKUP) begin
            if (match) begin
              out_data_nxt.found       = 1'b1;
              out_data_nxt.found_value = ram_rdata.value;
            end
          end else if (!ram_rdata.occupied || match) begin
            ram_we = 1'b1;
          end else begin
            out_data_nxt.status = ST_COLLISION;
          end
          out_valid_nxt = 1'b1;
          pop           = 1'b1;
          state_nxt     = B_IDLE;
        end
      end
      B_CLEAR: begin
        ram_we             = 1'b1;
        ram_waddr          = clr_idx_r;
        ram_wdata.occupied = 1'b0;
        clr_idx_nxt        = clr_idx_r + 1'b1;
        if (clr_idx_r == SW'(SLOT_COUNT - 1)) begin
          ready_nxt = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### tb/tb_direct_mapped_string_key_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_direct_mapped_string_key_table
// Drives lookup, insert, init and cleanup transactions into the table with
// random idle gaps on the request side and random stalls on the result side.
// A scoreboard object keeps its own copy of the slots and ready flag and
// checks every result in order, field by field.
// ----------------------------------------------------------------------------
module tb_direct_mapped_string_key_table;
  import dmskt_pkg::*;

  localparam int SLOT_COUNT = 64;
  localparam int MAX_KEY    = 8;
  localparam int POOL_SIZE  = 24;
  localparam int RAND_ITEMS = 1250;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  // when set, neither side idles
  bit calm = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  direct_mapped_string_key_table #(
    .SLOT_COUNT    (SLOT_COUNT),
    .MAX_KEY_BYTES (MAX_KEY)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  class table_tracker;
    logic [63:0] key_store [SLOT_COUNT];
    logic [3:0]  len_store [SLOT_COUNT];
    logic [7:0]  value_store [SLOT_COUNT];
    bit          occupied [SLOT_COUNT];
    bit          ready;
    out_item_t   pending_answers [$];
    int          fail_count;
    int          answer_count;

    function new();
      foreach (occupied[i]) occupied[i] = 1'b0;
      ready        = 1'b0;
      fail_count   = 0;
      answer_count = 0;
    endfunction

    function int pending();
      return pending_answers.size();
    endfunction

    function int unsigned slot_for(logic [63:0] key, int unsigned len);
      logic [63:0] h;
      h = '0;
      for (int i = 0; i < len; i++) h = h * 64'd37 + 64'(key[8*i +: 8]);
      return int'(h % SLOT_COUNT);
    endfunction

    function void note_request(in_item_t req);
      out_item_t   ans;
      int unsigned len;
      logic [63:0] key;
      int unsigned s;
      bit          hit;
      ans = '0;
      len = (req.key_length > MAX_KEY) ? MAX_KEY : req.key_length;
      // bytes past the length are dropped before hashing and storing
      key = (len >= 8) ? req.key_bytes : req.key_bytes & ((64'd1 << (8 * len)) - 64'd1);
      case (req.operation)
        OP_INIT: begin
          if (!ready) begin
            foreach (occupied[i]) occupied[i] = 1'b0;
            ready = 1'b1;
          end
        end
        OP_CLEANUP: ready = 1'b0;
        default: begin
          if (!ready) begin
            ans.status = ST_NOT_READY;
          end else begin
            s   = slot_for(key, len);
            hit = occupied[s] && len_store[s] == len && key_store[s] == key;
            if (req.operation == OP_LOOKUP) begin
              if (hit) begin
                ans.found       = 1'b1;
                ans.found_value = value_store[s];
              end
            end else if (!occupied[s]) begin
              key_store[s]   = key;
              len_store[s]   = 4'(len);
              value_store[s] = req.new_value;
              occupied[s]    = 1'b1;
            end else if (hit) begin
              value_store[s] = req.new_value;
            end else begin
              ans.status = ST_COLLISION;
            end
          end
        end
      endcase
      ans.ready_flag = ready;
      pending_answers.push_back(ans);
    endfunction

    task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      if (fail_count < 40)
        $display("tb: mismatch in %s on result %0d: got %0h, expected %0h",
                 what, answer_count, got, want);
      fail_count++;
    endtask

    task check_response(out_item_t got);
      out_item_t want;
      if (pending_answers.size() == 0) begin
        report_mismatch("result with no transaction pending", 8'(got), 8'h0);
        return;
      end
      want = pending_answers.pop_front();
      if (got.found !== want.found) report_mismatch("found", got.found, want.found);
      if (got.found_value !== want.found_value)
        report_mismatch("found_value", got.found_value, want.found_value);
      if (got.status !== want.status) report_mismatch("status", got.status, want.status);
      if (got.ready_flag !== want.ready_flag)
        report_mismatch("ready_flag", got.ready_flag, want.ready_flag);
      answer_count++;
    endtask
  endclass

  table_tracker tracker;

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 4);
    if (r < 85) return $urandom_range(5, 8);
    if (r < 93) return $urandom_range(9, 15);
    return 0;
  endfunction

  function automatic in_item_t make_item(op_e op, logic [63:0] key, int len,
                                         logic [7:0] value);
    in_item_t it;
    it.operation  = op;
    it.key_bytes  = key;
    it.key_length = 4'(len);
    it.new_value  = value;
    return it;
  endfunction

  task automatic send_item(in_item_t item, bit drain_first);
    int gap;
    gap = pick_gap();
    if (drain_first) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (tracker.pending() > 0);
    end else if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_request(item);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_response(out_data);
  end

  initial begin : result_side
    int hold;
    out_stall <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      hold = pick_gap();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  initial begin : watchdog
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    logic [63:0] key_pool [POOL_SIZE];
    int          len_pool [POOL_SIZE];
    logic [63:0] key;
    logic [63:0] long_key;
    int          len;
    int          idx;
    int          r;
    op_e         op;
    tracker  = new();
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: not-ready handling, empty key, zero bytes, long keys,
    // unused bytes, overwrite, collision, cleanup then re-init
    long_key = {$urandom, $urandom};
    send_item(make_item(OP_LOOKUP, 64'h6261, 2, 8'h00), 1'b0);
    send_item(make_item(OP_INSERT, 64'h6261, 2, 8'h11), 1'b0);
    send_item(make_item(OP_CLEANUP, 64'h0, 0, 8'h00), 1'b0);
    send_item(make_item(OP_INIT, 64'h0, 0, 8'h00), 1'b1);
    send_item(make_item(OP_INIT, 64'h0, 0, 8'h00), 1'b0);
    send_item(make_item(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 0, 8'hFF), 1'b0);
    send_item(make_item(OP_LOOKUP, 64'h1234_5678_9ABC_DEF0, 0, 8'h00), 1'b0);
    // a single zero byte hashes to slot 0 like the empty key, but differs
    send_item(make_item(OP_INSERT, 64'hDEAD_BEEF_CAFE_0000, 1, 8'h77), 1'b0);
    send_item(make_item(OP_LOOKUP, 64'h0, 1, 8'h00), 1'b0);
    send_item(make_item(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 8, 8'h00), 1'b0);
    send_item(make_item(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 15, 8'hFF), 1'b0);
    send_item(make_item(OP_INSERT, 64'hA5A5_A5A5_A5A5_A561, 1, 8'h5A), 1'b0);
    send_item(make_item(OP_LOOKUP, 64'h0123_4567_89AB_CD61, 1, 8'h00), 1'b0);
    // bytes 00 21 land on the same slot as 'a'
    send_item(make_item(OP_INSERT, 64'h2100, 2, 8'h33), 1'b0);
    send_item(make_item(OP_INSERT, 64'h61, 1, 8'hA5), 1'b0);
    send_item(make_item(OP_LOOKUP, 64'h61, 1, 8'h00), 1'b0);
    send_item(make_item(OP_LOOKUP, 64'h2100, 2, 8'h00), 1'b0);
    send_item(make_item(OP_INSERT, long_key, 12, 8'h3C), 1'b0);
    send_item(make_item(OP_LOOKUP, long_key, 8, 8'h00), 1'b0);
    send_item(make_item(OP_CLEANUP, 64'h0, 0, 8'h00), 1'b1);
    send_item(make_item(OP_LOOKUP, 64'h61, 1, 8'h00), 1'b0);
    send_item(make_item(OP_CLEANUP, 64'h0, 0, 8'h00), 1'b0);
    send_item(make_item(OP_INIT, 64'h0, 0, 8'h00), 1'b0);
    send_item(make_item(OP_LOOKUP, 64'h61, 1, 8'h00), 1'b0);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 150 == 0) calm = ($urandom_range(0, 3) == 0);
      // a small pool of keys gives hits, overwrites and collisions
      if (n % 200 == 0) begin
        foreach (key_pool[i]) begin
          key_pool[i] = {$urandom, $urandom};
          len_pool[i] = pick_len();
        end
      end
      r = $urandom_range(0, 99);
      if (!tracker.ready && $urandom_range(0, 3) != 0) op = OP_INIT;
      else if (r < 2) op = OP_CLEANUP;
      else if (r < 4) op = OP_INIT;
      else if (r < 48) op = OP_LOOKUP;
      else op = OP_INSERT;
      if ($urandom_range(0, 4) != 0) begin
        idx = $urandom_range(0, POOL_SIZE - 1);
        key = key_pool[idx];
        len = (len_pool[idx] >= MAX_KEY) ? $urandom_range(MAX_KEY, 15) : len_pool[idx];
        // scramble the bytes past the length; they must not matter
        for (int b = len; b < 8; b++) key[8*b +: 8] = 8'($urandom);
      end else begin
        key = {$urandom, $urandom};
        len = $urandom_range(0, 15);
      end
      send_item(make_item(op, key, len, 8'($urandom)), $urandom_range(0, 99) == 0);
    end

    in_valid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (tracker.fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sim.f
hdl/dmskt_pkg.sv
hdl/dmskt_ram.sv
hdl/dmskt_front.sv
hdl/dmskt_queue.sv
hdl/dmskt_back.sv
hdl/direct_mapped_string_key_table.sv
tb/tb_direct_mapped_string_key_table.sv
